// ===== sv/ntcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcb_pkg
// Shared constants, types and codes of the NTC beta-equation temperature unit.
// ----------------------------------------------------------------------------
package ntcb_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int LOG_IN_W     = 16;
  localparam int FRAC_BITS    = 24;
  localparam int LG_W         = 28;
  localparam int LN_W         = 28;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int BETA_W = 15;
  localparam int OFS_W  = 12;
  localparam int CFG_W  = 15;
  localparam logic [BETA_W-1:0] BETA_RESET = 15'd3950;

  localparam int N1_W   = 37;
  localparam int INVT_W = 39;
  localparam int D2_W   = 38;
  localparam int N2_W   = 41;
  localparam logic [INVT_W-1:0] INV_T25_Q32 = 39'd14405391;

  localparam int M_W    = 21;
  localparam int V_W    = 19;
  localparam int Q5_W   = 17;
  localparam logic [M_W-1:0] RECIP5 = 21'd419431;
  localparam int S_BIAS = 4370;

  localparam int TEMP_W = 16;
  localparam int TEMP_MAX = 32767;
  localparam int TEMP_MIN = -8192;

  localparam int LOG_LAT = FRAC_BITS + 2;
  localparam int LATENCY = LOG_LAT + 1 + N1_W + 1 + N2_W + 3;

  localparam logic REG_BETA   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RAW_ZERO = 2'd1,
    STATUS_RAW_FULL = 2'd2,
    STATUS_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    logic raw_zero;
    logic raw_full;
    logic neg;
    logic nonpos;
  } tag_t;

endpackage

// ===== sv/ntcb_log2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcb_log2
// Pipelined natural log in Q4.24: normalize, one squaring per stage, ln2 scale.
// ----------------------------------------------------------------------------
module ntcb_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [ntcb_pkg::LOG_IN_W-1:0] n_i,
  input  ntcb_pkg::tag_t                tag_i,
  output logic                          valid_o,
  output logic [ntcb_pkg::LN_W-1:0]     ln_o,
  output ntcb_pkg::tag_t                tag_o
);
  import ntcb_pkg::*;

  logic [FRAC_BITS:0] vld_q;
  logic [31:0]        x_q  [FRAC_BITS+1];
  logic [3:0]         k_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] fr_q [FRAC_BITS+1];
  tag_t               tg_q [FRAC_BITS+1];

  logic [3:0]  k_d;
  logic [4:0]  sh_d;
  logic [31:0] x_d;

  always_comb begin
    k_d = 4'd0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (n_i[i]) k_d = 4'(i);
    end
    sh_d = 5'd31 - {1'b0, k_d};
    x_d  = {16'b0, n_i} << sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= x_d;
    k_q[0]  <= k_d;
    fr_q[0] <= '0;
    tg_q[0] <= tag_i;
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] xs;
    assign sq = 64'(x_q[j]) * 64'(x_q[j]);
    assign xs = sq[63:31];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[j+1]  <= xs[32] ? xs[32:1] : xs[31:0];
      k_q[j+1]  <= k_q[j];
      fr_q[j+1] <= {fr_q[j][FRAC_BITS-2:0], xs[32]};
      tg_q[j+1] <= tg_q[j];
    end
  end

  logic [LG_W-1:0] lg;
  logic [59:0]     prod;
  logic            valid_q;
  logic [LN_W-1:0] ln_q;
  tag_t            tag_q;

  assign lg   = {k_q[FRAC_BITS], fr_q[FRAC_BITS]};
  assign prod = 60'(lg) * 60'(LN2_Q32) + 60'(64'd2147483648);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    ln_q  <= prod[59:32];
    tag_q <= tg_q[FRAC_BITS];
  end

  assign valid_o = valid_q;
  assign ln_o    = ln_q;
  assign tag_o   = tag_q;

endmodule

// ===== sv/ntcb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcb_div
// Pipelined restoring divider, one quotient bit per stage, payload alongside.
// ----------------------------------------------------------------------------
module ntcb_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic [NW:1]       vld_q;
  logic [DW+NW-1:0]  acc_q [1:NW];
  logic [DW-1:0]     den_q [1:NW];
  logic [PW-1:0]     pay_q [1:NW];

  for (genvar j = 0; j < NW; j++) begin : g_st
    logic             in_vld;
    logic [DW+NW-1:0] in_acc;
    logic [DW-1:0]    in_den;
    logic [PW-1:0]    in_pay;
    logic [DW+NW:0]   wide;
    logic [DW:0]      top;
    logic [DW:0]      diff;
    logic             ge;

    if (j == 0) begin : g_in
      assign in_vld = valid_i;
      assign in_acc = {{DW{1'b0}}, num_i};
      assign in_den = den_i;
      assign in_pay = pay_i;
    end else begin : g_mid
      assign in_vld = vld_q[j];
      assign in_acc = acc_q[j];
      assign in_den = den_q[j];
      assign in_pay = pay_q[j];
    end

    assign wide = {in_acc, 1'b0};
    assign top  = wide[DW+NW:NW];
    assign ge   = top >= {1'b0, in_den};
    assign diff = top - {1'b0, in_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[j+1] <= {ge ? diff[DW-1:0] : top[DW-1:0], wide[NW-1:1], ge};
      den_q[j+1] <= in_den;
      pay_q[j+1] <= in_pay;
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = acc_q[NW][NW-1:0];
  assign pay_o   = pay_q[NW];

endmodule

// ===== sv/thermistor_beta_to_celsius_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_beta_to_celsius_unit
// NTC thermistor sample to 1/16 degree Celsius via the beta equation.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                               Handshake
// request   in         raw_sample_i                          start_i & !busy_o
// result    out        temperature_o, status_o               done_o, one cycle
// config    in         cfg_idx_i, cfg_wdata_i                cfg_we_i
//
// One request per cycle; a new request is taken while earlier ones are in flight.
// The path runs through the squaring log pipeline and two bit-per-stage dividers.
// busy_o stays low; the receiver cannot stall and the pipeline never holds.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module thermistor_beta_to_celsius_unit #(
  parameter int ADC_BITS = ntcb_pkg::ADC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [ADC_BITS-1:0]         raw_sample_i,
  output logic                        done_o,
  output logic [ntcb_pkg::TEMP_W-1:0] temperature_o,
  output logic [1:0]                  status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ntcb_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import ntcb_pkg::*;

  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};

  logic [BETA_W-1:0] beta_q;
  logic [OFS_W-1:0]  ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
      ofs_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BETA:   beta_q <= cfg_wdata_i[BETA_W-1:0];
        REG_OFFSET: ofs_q  <= cfg_wdata_i[OFS_W-1:0];
        default:    ;
      endcase
    end
  end

  logic                req;
  tag_t                tag_in;
  logic [LOG_IN_W-1:0] na, nb;

  assign busy_o = 1'b0;
  assign req    = start_i & ~busy_o;
  assign tag_in = '{raw_zero: raw_sample_i == '0, raw_full: raw_sample_i == FS,
                    neg: 1'b0, nonpos: 1'b0};
  assign na     = LOG_IN_W'(FS - raw_sample_i);
  assign nb     = LOG_IN_W'(raw_sample_i);

  logic            lg_vld;
  logic [LN_W-1:0] ln_a, ln_b;
  tag_t            lg_tag;

  ntcb_log2 u_log_a (
    .clk_i, .rst_ni, .valid_i(req), .n_i(na), .tag_i(tag_in),
    .valid_o(lg_vld), .ln_o(ln_a), .tag_o(lg_tag)
  );

  ntcb_log2 u_log_b (
    .clk_i, .rst_ni, .valid_i(req), .n_i(nb), .tag_i(tag_in),
    .valid_o(), .ln_o(ln_b), .tag_o()
  );

  // stage A: ln ratio, magnitude, rounded dividend
  logic [LN_W:0]     lnr;
  logic [LN_W:0]     mag;
  logic [BETA_W-1:0] beta_eff;
  logic              a_vld_q;
  logic [N1_W-1:0]   a_num_q;
  logic [BETA_W-1:0] a_den_q;
  tag_t              a_tag_q, a_tag_d;

  always_comb begin
    lnr      = {1'b0, ln_a} - {1'b0, ln_b};
    mag      = lnr[LN_W] ? (~lnr + 1'b1) : lnr;
    beta_eff = (beta_q == '0) ? BETA_W'(1) : beta_q;
    a_tag_d  = lg_tag;
    a_tag_d.neg = lnr[LN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= lg_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    a_num_q <= N1_W'({mag[LN_W-1:0], 8'b0}) + N1_W'(beta_eff[BETA_W-1:1]);
    a_den_q <= beta_eff;
    a_tag_q <= a_tag_d;
  end

  logic            d1_vld;
  logic [N1_W-1:0] d1_quo;
  tag_t            d1_tag;

  ntcb_div #(.NW(N1_W), .DW(BETA_W), .PW($bits(tag_t))) u_div_beta (
    .clk_i, .rst_ni, .valid_i(a_vld_q), .num_i(a_num_q), .den_i(a_den_q),
    .pay_i(a_tag_q), .valid_o(d1_vld), .quo_o(d1_quo), .pay_o(d1_tag)
  );

  // stage B: reciprocal temperature and kelvin dividend
  logic [INVT_W-1:0] invt;
  logic              b_vld_q;
  logic [N2_W-1:0]   b_num_q;
  logic [D2_W-1:0]   b_den_q;
  tag_t              b_tag_q, b_tag_d;

  always_comb begin
    invt = d1_tag.neg ? (INV_T25_Q32 - INVT_W'(d1_quo))
                      : (INV_T25_Q32 + INVT_W'(d1_quo));
    b_tag_d = d1_tag;
    b_tag_d.nonpos = invt[INVT_W-1] | (invt == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    b_num_q <= (N2_W'(320) << 32) + N2_W'(invt[D2_W-1:1]);
    b_den_q <= invt[D2_W-1:0];
    b_tag_q <= b_tag_d;
  end

  logic            d2_vld;
  logic [N2_W-1:0] t320;
  tag_t            d2_tag;

  ntcb_div #(.NW(N2_W), .DW(D2_W), .PW($bits(tag_t))) u_div_invt (
    .clk_i, .rst_ni, .valid_i(b_vld_q), .num_i(b_num_q), .den_i(b_den_q),
    .pay_i(b_tag_q), .valid_o(d2_vld), .quo_o(t320), .pay_o(d2_tag)
  );

  // stage C: bias and clamp, m = t320 + 2 so that floor(m / 20) - 4370 = sixteenths
  logic [M_W-1:0] m_d;
  logic           c_vld_q;
  logic [V_W-1:0] c_v_q;
  tag_t           c_tag_q;

  assign m_d = (|t320[N2_W-1:20]) ? M_W'(21'h100000) : (M_W'(t320[19:0]) + M_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_v_q   <= m_d[M_W-1:2];
    c_tag_q <= d2_tag;
  end

  // stage D: divide by five via reciprocal
  logic [V_W+M_W-1:0] p5;
  logic               d_vld_q;
  logic [Q5_W-1:0]    d_q5_q;
  tag_t               d_tag_q;

  assign p5 = (V_W+M_W)'(c_v_q) * (V_W+M_W)'(RECIP5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q5_q  <= p5[M_W+Q5_W-1:M_W];
    d_tag_q <= c_tag_q;
  end

  // stage E: offset, saturation, status
  logic signed [Q5_W+1:0] sum;
  logic [TEMP_W-1:0]      temp_d;
  status_e                stat_d;
  logic                   e_vld_q;
  logic [TEMP_W-1:0]      temp_q;
  status_e                stat_q;

  always_comb begin
    sum = $signed({2'b00, d_q5_q}) - $signed((Q5_W+2)'(S_BIAS))
        + $signed({{(Q5_W+2-OFS_W){ofs_q[OFS_W-1]}}, ofs_q});
    temp_d = sum[TEMP_W-1:0];
    stat_d = STATUS_OK;
    if (d_tag_q.raw_zero) begin
      temp_d = '0;
      stat_d = STATUS_RAW_ZERO;
    end else if (d_tag_q.raw_full) begin
      temp_d = '0;
      stat_d = STATUS_RAW_FULL;
    end else if (d_tag_q.nonpos || sum > $signed((Q5_W+2)'(TEMP_MAX))) begin
      temp_d = TEMP_W'(TEMP_MAX);
      stat_d = STATUS_SAT;
    end else if (sum < $signed((Q5_W+2)'(TEMP_MIN))) begin
      temp_d = TEMP_W'(TEMP_MIN);
      stat_d = STATUS_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    stat_q <= stat_d;
  end

  assign done_o        = e_vld_q;
  assign temperature_o = temp_q;
  assign status_o      = stat_q;

endmodule

// ===== sv/ntcb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcb_checker
// Port-level checks of the temperature unit, bound to the top level.
// ----------------------------------------------------------------------------
module ntcb_checker #(
  parameter int ADC_BITS = ntcb_pkg::ADC_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [ADC_BITS-1:0]         raw_sample_i,
  input logic                        done_o,
  input logic [ntcb_pkg::TEMP_W-1:0] temperature_o,
  input logic [1:0]                  status_o
);
  import ntcb_pkg::*;

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without request");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && raw_sample_i == '0) |->
      ##LATENCY (done_o && status_o == STATUS_RAW_ZERO && temperature_o == '0))
    else $error("raw zero not flagged");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_OK) |-> ($signed(temperature_o) >= TEMP_MIN))
    else $error("valid result below range");

endmodule

bind thermistor_beta_to_celsius_unit ntcb_checker #(.ADC_BITS(ADC_BITS)) u_ntcb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .raw_sample_i(raw_sample_i), .done_o(done_o), .temperature_o(temperature_o),
  .status_o(status_o)
);
